// ===== hw/rtl/ljps_pkg.sv =====
package ljps_pkg;

  typedef struct packed {
    logic signed [23:0] first_x;
    logic signed [23:0] first_y;
    logic signed [23:0] first_z;
    logic [15:0]        first_radius;
    logic               first_on;
    logic signed [23:0] second_x;
    logic signed [23:0] second_y;
    logic signed [23:0] second_z;
    logic [15:0]        second_radius;
    logic               second_on;
    logic               last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] total_energy;
    logic               overflowed;
  } out_item_t;

  // Classified pair handed from front to back
  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_FAR  = 2'd1,
    KIND_NEAR = 2'd2,
    KIND_LJ   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [49:0] d2;
    logic [16:0] rsum;
    logic        last;
  } job_t;

  localparam logic [2:0] REG_NEAR_CUT  = 3'd0;
  localparam logic [2:0] REG_FAR_CUT   = 3'd1;
  localparam logic [2:0] REG_NEAR_E    = 3'd2;
  localparam logic [2:0] REG_FAR_E     = 3'd3;
  localparam logic [2:0] REG_SIGMA     = 3'd4;
  localparam logic [2:0] REG_DEPTH     = 3'd5;
  localparam logic [2:0] REG_XPRE      = 3'd6;

  // ratio clamp, 32.0 in Q.16
  localparam logic [21:0] Q_CAP = 22'd2097152;
  localparam logic signed [48:0] SUM_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] SUM_MIN = -49'sd140737488355328;

endpackage

// ===== hw/rtl/ljps_front.sv =====
module ljps_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ljps_pkg::in_item_t in_data,
  input  logic [23:0]        near_cut,
  input  logic [23:0]        far_cut,
  input  logic [22:0]        x_pre,
  output logic               job_valid,
  input  logic               job_take,
  output ljps_pkg::job_t     job
);
  // Stage 0: capture item
  typedef enum logic [3:0] {
    F_IDLE = 4'b0001, F_SQ = 4'b0010, F_SUM = 4'b0100, F_OUT = 4'b1000
  } fst_t;
  fst_t st_r, st_nxt;
  ljps_pkg::in_item_t it_r;
  logic [24:0] ax_r, ay_r, az_r;
  logic [49:0] sx_r, sy_r, sz_r;
  logic        pass_r;
  ljps_pkg::job_t job_r;
  logic first_out_r;

  // job register is loaded in the first F_OUT cycle, offered from the second
  assign in_stall  = (st_r != F_IDLE);
  assign job_valid = (st_r == F_OUT) && !first_out_r;
  assign job       = job_r;

  logic signed [24:0] dx, dy, dz;
  assign dx = 25'(it_r.first_x) - 25'(it_r.second_x);
  assign dy = 25'(it_r.first_y) - 25'(it_r.second_y);
  assign dz = 25'(it_r.first_z) - 25'(it_r.second_z);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: if (in_valid) st_nxt = F_SQ;
      F_SQ:   st_nxt = F_SUM;
      F_SUM:  st_nxt = F_OUT;
      F_OUT:  if (job_take) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= F_IDLE;
    else st_r <= st_nxt;
    if (st_r == F_IDLE && in_valid) it_r <= in_data;
    // gaps and magnitude
    if (st_r == F_IDLE) begin
      ax_r <= '0; ay_r <= '0; az_r <= '0;
    end
    if (st_r == F_SQ) begin
      ax_r   <= dx[24] ? 25'(-dx) : 25'(dx);
      ay_r   <= dy[24] ? 25'(-dy) : 25'(dy);
      az_r   <= dz[24] ? 25'(-dz) : 25'(dz);
    end
    // squares, one 25x25 multiply per axis
    if (st_r == F_SUM) begin
      sx_r <= 50'(ax_r) * 50'(ax_r);
      sy_r <= 50'(ay_r) * 50'(ay_r);
      sz_r <= 50'(az_r) * 50'(az_r);
      pass_r <= it_r.first_on && it_r.second_on && (ax_r <= 25'(x_pre));
    end
  end

  // Combine squares and classify in the output slot
  logic [49:0] d2c;
  assign d2c = sx_r + sy_r + sz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) first_out_r <= 1'b0;
    else first_out_r <= (st_r == F_SUM);
    if (first_out_r) begin
      job_r.d2   <= d2c;
      job_r.rsum <= 17'(it_r.first_radius) + 17'(it_r.second_radius);
      job_r.last <= it_r.last_pair;
      if (!pass_r) job_r.kind <= ljps_pkg::KIND_SKIP;
      else if (d2c > {10'd0, far_cut, 16'd0}) job_r.kind <= ljps_pkg::KIND_FAR;
      else if (d2c < {10'd0, near_cut, 16'd0}) job_r.kind <= ljps_pkg::KIND_NEAR;
      else job_r.kind <= ljps_pkg::KIND_LJ;
    end
  end
endmodule

// ===== hw/rtl/ljps_queue.sv =====
module ljps_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_take,
  input  ljps_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_take,
  output ljps_pkg::job_t rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  ljps_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_wr, do_rd;

  assign wr_take  = wr_valid && (cnt_r != (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr = wr_take;
  assign do_rd = rd_valid && rd_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
    if (do_wr) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== hw/rtl/ljps_back.sv =====
module ljps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 job_valid,
  output logic                 job_take,
  input  ljps_pkg::job_t       job,
  input  logic signed [31:0]   near_e,
  input  logic signed [31:0]   far_e,
  input  logic [15:0]          sigma_f,
  input  logic [15:0]          depth,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ljps_pkg::out_item_t  out_data
);
  typedef enum logic [10:0] {
    B_IDLE = 11'b00000000001, B_SIG  = 11'b00000000010, B_S2 = 11'b00000000100,
    B_DIV  = 11'b00000001000, B_Q2   = 11'b00000010000, B_Q3 = 11'b00000100000,
    B_Q6   = 11'b00001000000, B_MAG  = 11'b00010000000, B_EN = 11'b00100000000,
    B_ACC  = 11'b01000000000, B_EMIT = 11'b10000000000
  } bst_t;
  bst_t st_r;
  ljps_pkg::job_t j_r;
  logic [33:0] sig_r;
  logic [63:0] num_r;     // dividend shift register
  logic [50:0] rem_r;
  logic [6:0]  cnt_r;
  logic [21:0] q_r;       // ratio, up to 32.0 in Q.16
  logic [63:0] prod_r;
  logic [31:0] q3_r;      // q^3, up to 2^31
  logic [46:0] mag_r;     // |q^6 - q^3|, up to 2^46
  logic        neg_r;
  logic signed [50:0] e_r;
  logic signed [47:0] sum_r;
  logic        sat_r;
  logic        ov_r;
  ljps_pkg::out_item_t od_r;

  assign job_take  = (st_r == B_IDLE) && job_valid;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  // one restoring division step per cycle
  logic [50:0] trial;
  logic [51:0] diff;
  assign trial = {rem_r[49:0], num_r[63]};
  assign diff  = {1'b0, trial} - {2'b0, j_r.d2};

  // rounded power chain value
  logic [63:0] rnd;
  logic [46:0] pw;
  assign rnd = prod_r + 64'd32768;
  assign pw  = rnd[62:16];
  logic signed [51:0] tsum;
  assign tsum = 52'(sum_r) + 52'(e_r);
  logic [63:0] em;
  assign em = 64'(depth) * 64'(mag_r) + 64'd8192;

  // result register frees when empty or taken this cycle
  logic emit_go;
  assign emit_go = (st_r == B_EMIT) && (!ov_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE; sum_r <= '0; sat_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (emit_go) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (st_r)
        B_IDLE: if (job_valid) begin
          j_r <= job;
          unique case (job.kind)
            ljps_pkg::KIND_SKIP: begin e_r <= '0; st_r <= B_ACC; end
            ljps_pkg::KIND_FAR:  begin e_r <= 51'(far_e); st_r <= B_ACC; end
            ljps_pkg::KIND_NEAR: begin e_r <= 51'(near_e); st_r <= B_ACC; end
            default:             st_r <= B_SIG;
          endcase
        end
        B_SIG: begin
          sig_r <= 34'(sigma_f) * 34'(j_r.rsum) + 34'd8192;
          st_r <= B_S2;
        end
        B_S2: begin
          // sigma < 2^20, s2 < 2^40, numerator < 2^56
          num_r <= {(64'(sig_r[33:14]) * 64'(sig_r[33:14])) << 16} << 8;
          rem_r <= '0; cnt_r <= 7'd56;
          st_r <= (j_r.d2 == '0) ? B_Q2 : B_DIV;
          q_r <= ljps_pkg::Q_CAP;
          prod_r <= 64'(ljps_pkg::Q_CAP) * 64'(ljps_pkg::Q_CAP);
        end
        B_DIV: begin
          num_r <= {num_r[62:0], ~diff[51]};
          rem_r <= diff[51] ? trial : diff[50:0];
          cnt_r <= cnt_r - 7'd1;
          // quotient sits in num_r low bits after the last step
          if (cnt_r == 7'd1) st_r <= B_MAG;
        end
        B_Q2: begin
          prod_r <= 64'(pw[26:0]) * 64'(q_r);
          st_r <= B_Q3;
        end
        B_Q3: begin
          q3_r <= pw[31:0];
          prod_r <= 64'(pw[31:0]) * 64'(pw[31:0]);
          st_r <= B_Q6;
        end
        B_Q6: begin
          st_r <= B_EN;
          neg_r <= pw < 47'(q3_r);
          mag_r <= (pw < 47'(q3_r)) ? 47'(q3_r) - pw : pw - 47'(q3_r);
        end
        B_MAG: begin
          // clamp quotient and start power chain
          if (num_r[55:0] > 56'(ljps_pkg::Q_CAP)) begin
            q_r <= ljps_pkg::Q_CAP;
            prod_r <= 64'(ljps_pkg::Q_CAP) * 64'(ljps_pkg::Q_CAP);
          end else begin
            q_r <= num_r[21:0];
            prod_r <= 64'(num_r[21:0]) * 64'(num_r[21:0]);
          end
          st_r <= B_Q2;
        end
        B_EN: begin
          e_r <= neg_r ? -51'(em[63:14]) : 51'(em[63:14]);
          st_r <= B_ACC;
        end
        B_ACC: begin
          if (tsum > ljps_pkg::SUM_MAX) begin
            sum_r <= 48'(ljps_pkg::SUM_MAX); sat_r <= 1'b1;
          end else if (tsum < ljps_pkg::SUM_MIN) begin
            sum_r <= 48'(ljps_pkg::SUM_MIN); sat_r <= 1'b1;
          end else sum_r <= 48'(tsum);
          st_r <= j_r.last ? B_EMIT : B_IDLE;
        end
        B_EMIT: if (emit_go) begin
          od_r.total_energy <= sum_r;
          od_r.overflowed   <= sat_r;
          sum_r <= '0; sat_r <= 1'b0;
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/lennard_jones_pair_energy_sum.sv =====
// Lennard-Jones 12-6 pair energy accumulator.
// Input channel (in_valid/in_stall/in_data): one atom pair per item.
// Output channel (out_valid/out_stall/out_data): one item after each pair
// marked last_pair, carrying the saturated sum and a sticky overflow flag;
// the sum is then cleared.
// Configuration: write cfg_we with cfg_index (0..6) and cfg_wdata while idle.
// The front stage handles one pair at a time and holds in_stall until its
// job is queued: gaps, squares, range classification. A queue of QDEPTH
// entries (2 by default) feeds the back stage. Back stage: pairs outside
// the Lennard-Jones band take a fixed energy (skipped pairs take zero);
// pairs inside pass the 56-step restoring divider (one quotient bit per
// cycle), bypassed when d2 is zero, then the power and energy multiplies.
// A last pair also passes through B_EMIT to load the output.
// A stalled output holds its item; the back stage waits at the next
// result until the output register frees, while the front keeps filling
// the queue. Synchronous reset restores register defaults and clears the
// sum, flag and queue.
module lennard_jones_pair_energy_sum #(
  parameter int QDEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ljps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ljps_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  logic [23:0] near_cut_r, far_cut_r;
  logic signed [31:0] near_e_r, far_e_r;
  logic [15:0] sigma_r, depth_r;
  logic [22:0] xpre_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_cut_r <= 24'd256; far_cut_r <= 24'd25600;
      near_e_r <= 32'sd65470464; far_e_r <= '0;
      sigma_r <= 16'd16876; depth_r <= 16'd11469; xpre_r <= 23'd40960;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ljps_pkg::REG_NEAR_CUT: near_cut_r <= cfg_wdata[23:0];
        ljps_pkg::REG_FAR_CUT:  far_cut_r  <= cfg_wdata[23:0];
        ljps_pkg::REG_NEAR_E:   near_e_r   <= cfg_wdata;
        ljps_pkg::REG_FAR_E:    far_e_r    <= cfg_wdata;
        ljps_pkg::REG_SIGMA:    sigma_r    <= cfg_wdata[15:0];
        ljps_pkg::REG_DEPTH:    depth_r    <= cfg_wdata[15:0];
        ljps_pkg::REG_XPRE:     xpre_r     <= cfg_wdata[22:0];
        default: ;
      endcase
    end
  end

  logic fj_valid, fj_take, qj_valid, qj_take;
  ljps_pkg::job_t fj, qj;

  ljps_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .near_cut(near_cut_r), .far_cut(far_cut_r), .x_pre(xpre_r),
    .job_valid(fj_valid), .job_take(fj_take), .job(fj)
  );

  ljps_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_take(fj_take), .wr_data(fj),
    .rd_valid(qj_valid), .rd_take(qj_take), .rd_data(qj)
  );

  ljps_back u_back (
    .clk, .rst_n, .job_valid(qj_valid), .job_take(qj_take), .job(qj),
    .near_e(near_e_r), .far_e(far_e_r), .sigma_f(sigma_r), .depth(depth_r),
    .out_valid, .out_stall, .out_data
  );
endmodule
